@@ sv/tlsa_pkg.sv @@
// Shared types and constants for the two-level submit admission block.
// No dependencies; imported by tlsa_dp, tlsa_ctrl and the top level.
package tlsa_pkg;

  localparam int LIST_DEPTH  = 16;
  localparam int JOB_ID_BITS = 8;
  localparam int IDX_W       = $clog2(LIST_DEPTH);
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);

  localparam logic [7:0] DEF_SUBMIT = 8'd5;
  localparam logic [7:0] DEF_JOB    = 8'd100;

  // action codes
  localparam logic [2:0] ACT_REQUEST   = 3'd0;
  localparam logic [2:0] ACT_COMPLETE  = 3'd1;
  localparam logic [2:0] ACT_CANCEL    = 3'd2;
  localparam logic [2:0] ACT_ALREADY   = 3'd3;
  localparam logic [2:0] ACT_REBALANCE = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_ANSWER   = 2'd0;
  localparam logic [1:0] KIND_TO_ALLOW = 2'd1;
  localparam logic [1:0] KIND_TO_PROG  = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // register indexes
  localparam logic CFG_SUBMIT = 1'b0;
  localparam logic CFG_JOB    = 1'b1;

  typedef logic [JOB_ID_BITS-1:0] job_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [1:0] {LST_W, LST_A, LST_Q, LST_P} list_t;
  typedef enum logic [1:0] {OP_FIND, OP_REMOVE, OP_POP, OP_APPEND} dp_op_t;
  typedef enum logic [1:0] {JSEL_JOB, JSEL_HOLD, JSEL_ZERO} jsel_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] job_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] job_out;
    logic       granted;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       start;
    dp_op_t     op;
    list_t      sel;
    logic       src_hold;
    logic       emit;
    logic [1:0] kind;
    jsel_t      jsel;
    logic       granted;
    logic [1:0] status;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [2:0] action;
    logic       w_nonempty;
    logic       q_nonempty;
    logic       a_full;
    logic       w_full;
    logic       q_full;
    logic       p_full;
    logic       a_below;
    logic       p_below;
    logic       out_free;
  } dp_stat_t;

endpackage

@@ sv/tlsa_dp.sv @@
// Datapath: the four job lists, their counts, limit registers and result register.
// Depends on tlsa_pkg; driven by tlsa_ctrl through dp_cmd_t.
module tlsa_dp
  import tlsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_data,
  input  logic       out_stall,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  dp_cmd_t    cmd,
  output dp_stat_t   st
);

  job_t wl [LIST_DEPTH];
  job_t al [LIST_DEPTH];
  job_t ql [LIST_DEPTH];
  job_t pl [LIST_DEPTH];
  cnt_t cnt [4];

  logic [7:0] submit_limit;
  logic [7:0] job_limit;
  logic [2:0] action_r;
  job_t       job_r;
  job_t       hold;
  logic       busy;
  dp_op_t     op_r;
  list_t      sel_r;
  logic       src_r;
  cnt_t       ptr;
  cnt_t       idx_r;
  logic       found;
  logic       done;

  cnt_t             raddr;
  logic [IDX_W-1:0] ridx;
  job_t             rd;
  cnt_t             cur_cnt;
  cnt_t             ptr_inc;
  logic             we;
  logic [IDX_W-1:0] widx;
  job_t             wdata;
  job_t             emit_job;
  logic [7:0]       sl;
  logic [7:0]       jl;

  localparam cnt_t DEPTH_C = CNT_W'(LIST_DEPTH);

  assign ptr_inc = ptr + cnt_t'(1);
  assign cur_cnt = cnt[sel_r];

  always_comb begin
    case (op_r)
      OP_REMOVE: raddr = ptr_inc;
      OP_POP:    raddr = '0;
      default:   raddr = ptr;
    endcase
  end
  assign ridx = raddr[IDX_W-1:0];

  always_comb begin
    unique case (sel_r)
      LST_W:   rd = wl[ridx];
      LST_A:   rd = al[ridx];
      LST_Q:   rd = ql[ridx];
      default: rd = pl[ridx];
    endcase
  end

  always_comb begin
    we    = 1'b0;
    widx  = ptr[IDX_W-1:0];
    wdata = rd;
    if (busy && op_r == OP_APPEND && cur_cnt < DEPTH_C) begin
      we    = 1'b1;
      widx  = cur_cnt[IDX_W-1:0];
      wdata = src_r ? hold : job_r;
    end else if (busy && op_r == OP_REMOVE && ptr_inc < cur_cnt) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      unique case (sel_r)
        LST_W:   wl[widx] <= wdata;
        LST_A:   al[widx] <= wdata;
        LST_Q:   ql[widx] <= wdata;
        default: pl[widx] <= wdata;
      endcase
    end
    if (cmd.load) begin
      action_r <= in_data.action;
      job_r    <= JOB_ID_BITS'(in_data.job_id);
    end
    if (!cmd.start && busy && op_r == OP_POP) begin
      hold <= rd;
    end
    if (!cmd.start && busy && op_r == OP_FIND && ptr < cur_cnt && rd == job_r) begin
      idx_r <= ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      done         <= 1'b0;
      found        <= 1'b0;
      op_r         <= OP_FIND;
      sel_r        <= LST_W;
      src_r        <= 1'b0;
      ptr          <= '0;
      cnt          <= '{default: '0};
      submit_limit <= DEF_SUBMIT;
      job_limit    <= DEF_JOB;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SUBMIT: submit_limit <= cfg_data;
          default:    job_limit    <= cfg_data;
        endcase
      end
      if (cmd.start) begin
        busy  <= 1'b1;
        op_r  <= cmd.op;
        sel_r <= cmd.sel;
        src_r <= cmd.src_hold;
        ptr   <= (cmd.op == OP_REMOVE) ? idx_r : '0;
        if (cmd.op == OP_FIND) begin
          found <= 1'b0;
        end
      end else if (busy) begin
        unique case (op_r)
          OP_FIND: begin
            if (ptr < cur_cnt) begin
              if (rd == job_r) begin
                found <= 1'b1;
                busy  <= 1'b0;
                done  <= 1'b1;
              end else begin
                ptr <= ptr_inc;
              end
            end else begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_REMOVE: begin
            if (ptr_inc < cur_cnt) begin
              ptr <= ptr_inc;
            end else begin
              if (cur_cnt != '0) begin
                cnt[sel_r] <= cur_cnt - cnt_t'(1);
              end
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_POP: begin
            // head captured; shift the rest down from entry zero
            op_r <= OP_REMOVE;
            ptr  <= '0;
          end
          default: begin
            if (cur_cnt < DEPTH_C) begin
              cnt[sel_r] <= cur_cnt + cnt_t'(1);
            end
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  // result register
  always_comb begin
    unique case (cmd.jsel)
      JSEL_JOB:  emit_job = job_r;
      JSEL_HOLD: emit_job = hold;
      default:   emit_job = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.kind    <= cmd.kind;
      out_data.job_out <= 8'(emit_job);
      out_data.granted <= cmd.granted;
      out_data.status  <= cmd.status;
      out_data.last    <= cmd.last;
    end
  end

  assign sl = (submit_limit == 8'd0) ? DEF_SUBMIT : submit_limit;
  assign jl = (job_limit == 8'd0) ? DEF_JOB : job_limit;

  always_comb begin
    st.done       = done;
    st.found      = found;
    st.action     = action_r;
    st.w_nonempty = cnt[LST_W] != '0;
    st.q_nonempty = cnt[LST_Q] != '0;
    st.a_full     = cnt[LST_A] >= DEPTH_C;
    st.w_full     = cnt[LST_W] >= DEPTH_C;
    st.q_full     = cnt[LST_Q] >= DEPTH_C;
    st.p_full     = cnt[LST_P] >= DEPTH_C;
    st.a_below    = 8'(cnt[LST_A]) < jl;
    st.p_below    = 8'(cnt[LST_P]) < sl;
    st.out_free   = !out_valid || !out_stall;
  end

endmodule

@@ sv/tlsa_ctrl.sv @@
// Controller: sequences list operations and result emission for each transaction.
// Depends on tlsa_pkg; commands tlsa_dp.
module tlsa_ctrl
  import tlsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH,
    S_RQ_FQ, S_RQ_FP, S_RQ_FW, S_RQ_FA, S_RQ_DEC, S_RQ_APPA, S_RQ_APPX, S_ANS,
    S_CA_FA, S_CA_RA, S_CA_CHKA, S_CA_POPW, S_CA_APPA, S_CA_EMA, S_CA_FW, S_CA_RW,
    S_CO_FP, S_CO_RP, S_CO_CHKP, S_CO_POPQ, S_CO_APPP, S_CO_EMP, S_CO_FQ, S_CO_RQ,
    S_AS_FA, S_AS_APP,
    S_RB_CHKA, S_RB_POPW, S_RB_APPA, S_RB_EMA,
    S_RB_CHKP, S_RB_POPQ, S_RB_APPP, S_RB_EMP,
    S_FIN
  } state_t;

  state_t     state, state_next;
  logic       pend;
  logic       go;
  logic       ans_g, ans_g_next;
  logic [1:0] ans_s, ans_s_next;
  logic       in_al, in_al_next;
  list_t      app_sel, app_sel_next;
  logic [1:0] fin_st, fin_st_next;
  logic       can_pa, can_pp;

  assign go       = pend && st.done;
  assign can_pa   = st.a_below && !st.a_full && st.w_nonempty;
  assign can_pp   = st.p_below && !st.p_full && st.q_nonempty;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    ans_g_next   = ans_g;
    ans_s_next   = ans_s;
    in_al_next   = in_al;
    app_sel_next = app_sel;
    fin_st_next  = fin_st;
    cmd          = '0;
    cmd.op       = OP_FIND;
    cmd.sel      = LST_W;
    cmd.jsel     = JSEL_JOB;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        fin_st_next = ST_OK;
        case (st.action) inside
          ACT_REQUEST:   state_next = S_RQ_FQ;
          ACT_COMPLETE:  state_next = S_CO_FP;
          ACT_CANCEL:    state_next = S_CA_FA;
          ACT_ALREADY:   state_next = S_AS_FA;
          ACT_REBALANCE: state_next = S_RB_CHKA;
          default:       state_next = S_FIN;
        endcase
      end

      // request
      S_RQ_FQ: begin
        cmd.start = !pend; cmd.op = OP_FIND; cmd.sel = LST_Q;
        if (go) begin
          ans_g_next = 1'b0; ans_s_next = ST_OK;
          state_next = st.found ? S_ANS : S_RQ_FP;
        end
      end
      S_RQ_FP: begin
        cmd.start = !pend; cmd.op = OP_FIND; cmd.sel = LST_P;
        if (go) begin
          ans_g_next = 1'b1; ans_s_next = ST_OK;
          state_next = st.found ? S_ANS : S_RQ_FW;
        end
      end
      S_RQ_FW: begin
        cmd.start = !pend; cmd.op = OP_FIND; cmd.sel = LST_W;
        if (go) begin
          ans_g_next = 1'b0; ans_s_next = ST_OK;
          state_next = st.found ? S_ANS : S_RQ_FA;
        end
      end
      S_RQ_FA: begin
        cmd.start = !pend; cmd.op = OP_FIND; cmd.sel = LST_A;
        if (go) begin
          in_al_next = st.found;
          state_next = S_RQ_DEC;
        end
      end
      S_RQ_DEC: begin
        ans_g_next = 1'b0;
        ans_s_next = ST_OK;
        state_next = S_ANS;
        if (!in_al && st.a_below && st.w_nonempty) begin
          ans_s_next = ST_FAULT;
        end else if (!in_al && !st.a_below) begin
          // at or over the job limit: park in wanted
          if (st.w_full) begin
            ans_s_next = ST_FULL;
          end else begin
            app_sel_next = LST_W;
            state_next   = S_RQ_APPX;
          end
        end else if (st.p_below && st.q_nonempty) begin
          ans_s_next = ST_FAULT;
        end else if (!in_al && st.a_full) begin
          ans_s_next = ST_FULL;
        end else if (st.p_below) begin
          if (st.p_full) begin
            ans_s_next = ST_FULL;
          end else begin
            ans_g_next   = 1'b1;
            app_sel_next = LST_P;
            state_next   = !in_al ? S_RQ_APPA : S_RQ_APPX;
          end
        end else begin
          if (st.q_full) begin
            ans_s_next = ST_FULL;
          end else begin
            app_sel_next = LST_Q;
            state_next   = !in_al ? S_RQ_APPA : S_RQ_APPX;
          end
        end
      end
      S_RQ_APPA: begin
        cmd.start = !pend; cmd.op = OP_APPEND; cmd.sel = LST_A;
        if (go) state_next = S_RQ_APPX;
      end
      S_RQ_APPX: begin
        cmd.start = !pend; cmd.op = OP_APPEND; cmd.sel = app_sel;
        if (go) state_next = S_ANS;
      end
      S_ANS: begin
        cmd.kind = KIND_ANSWER; cmd.granted = ans_g; cmd.status = ans_s; cmd.last = 1'b1;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end

      // cancel: allowed/wanted side, then falls into complete
      S_CA_FA: begin
        cmd.start = !pend; cmd.op = OP_FIND; cmd.sel = LST_A;
        if (go) state_next = st.found ? S_CA_RA : S_CA_FW;
      end
      S_CA_RA: begin
        cmd.start = !pend; cmd.op = OP_REMOVE; cmd.sel = LST_A;
        if (go) state_next = S_CA_CHKA;
      end
      S_CA_CHKA: state_next = can_pa ? S_CA_POPW : S_CO_FP;
      S_CA_POPW: begin
        cmd.start = !pend; cmd.op = OP_POP; cmd.sel = LST_W;
        if (go) state_next = S_CA_APPA;
      end
      S_CA_APPA: begin
        cmd.start = !pend; cmd.op = OP_APPEND; cmd.sel = LST_A; cmd.src_hold = 1'b1;
        if (go) state_next = S_CA_EMA;
      end
      S_CA_EMA: begin
        cmd.kind = KIND_TO_ALLOW; cmd.jsel = JSEL_HOLD;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_CO_FP;
        end
      end
      S_CA_FW: begin
        cmd.start = !pend; cmd.op = OP_FIND; cmd.sel = LST_W;
        if (go) state_next = st.found ? S_CA_RW : S_CO_FP;
      end
      S_CA_RW: begin
        cmd.start = !pend; cmd.op = OP_REMOVE; cmd.sel = LST_W;
        if (go) state_next = S_CO_FP;
      end

      // complete: in-progress/queued side
      S_CO_FP: begin
        cmd.start = !pend; cmd.op = OP_FIND; cmd.sel = LST_P;
        if (go) state_next = st.found ? S_CO_RP : S_CO_FQ;
      end
      S_CO_RP: begin
        cmd.start = !pend; cmd.op = OP_REMOVE; cmd.sel = LST_P;
        if (go) state_next = S_CO_CHKP;
      end
      S_CO_CHKP: state_next = can_pp ? S_CO_POPQ : S_FIN;
      S_CO_POPQ: begin
        cmd.start = !pend; cmd.op = OP_POP; cmd.sel = LST_Q;
        if (go) state_next = S_CO_APPP;
      end
      S_CO_APPP: begin
        cmd.start = !pend; cmd.op = OP_APPEND; cmd.sel = LST_P; cmd.src_hold = 1'b1;
        if (go) state_next = S_CO_EMP;
      end
      S_CO_EMP: begin
        cmd.kind = KIND_TO_PROG; cmd.jsel = JSEL_HOLD;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_FIN;
        end
      end
      S_CO_FQ: begin
        cmd.start = !pend; cmd.op = OP_FIND; cmd.sel = LST_Q;
        if (go) state_next = st.found ? S_CO_RQ : S_FIN;
      end
      S_CO_RQ: begin
        cmd.start = !pend; cmd.op = OP_REMOVE; cmd.sel = LST_Q;
        if (go) state_next = S_FIN;
      end

      // already submitted
      S_AS_FA: begin
        cmd.start = !pend; cmd.op = OP_FIND; cmd.sel = LST_A;
        if (go) begin
          if (st.found) begin
            state_next = S_FIN;
          end else if (st.a_full) begin
            fin_st_next = ST_FULL;
            state_next  = S_FIN;
          end else begin
            state_next = S_AS_APP;
          end
        end
      end
      S_AS_APP: begin
        cmd.start = !pend; cmd.op = OP_APPEND; cmd.sel = LST_A;
        if (go) state_next = S_FIN;
      end

      // rebalance
      S_RB_CHKA: state_next = can_pa ? S_RB_POPW : S_RB_CHKP;
      S_RB_POPW: begin
        cmd.start = !pend; cmd.op = OP_POP; cmd.sel = LST_W;
        if (go) state_next = S_RB_APPA;
      end
      S_RB_APPA: begin
        cmd.start = !pend; cmd.op = OP_APPEND; cmd.sel = LST_A; cmd.src_hold = 1'b1;
        if (go) state_next = S_RB_EMA;
      end
      S_RB_EMA: begin
        cmd.kind = KIND_TO_ALLOW; cmd.jsel = JSEL_HOLD;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_RB_CHKA;
        end
      end
      S_RB_CHKP: state_next = can_pp ? S_RB_POPQ : S_FIN;
      S_RB_POPQ: begin
        cmd.start = !pend; cmd.op = OP_POP; cmd.sel = LST_Q;
        if (go) state_next = S_RB_APPP;
      end
      S_RB_APPP: begin
        cmd.start = !pend; cmd.op = OP_APPEND; cmd.sel = LST_P; cmd.src_hold = 1'b1;
        if (go) state_next = S_RB_EMP;
      end
      S_RB_EMP: begin
        cmd.kind = KIND_TO_PROG; cmd.jsel = JSEL_HOLD;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_RB_CHKP;
        end
      end

      default: begin
        // done result closes every non-request transaction
        cmd.kind   = KIND_DONE;
        cmd.status = fin_st;
        cmd.last   = 1'b1;
        case (st.action) inside
          ACT_COMPLETE, ACT_CANCEL, ACT_ALREADY: cmd.jsel = JSEL_JOB;
          default:                               cmd.jsel = JSEL_ZERO;
        endcase
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pend    <= 1'b0;
      ans_g   <= 1'b0;
      ans_s   <= ST_OK;
      in_al   <= 1'b0;
      app_sel <= LST_W;
      fin_st  <= ST_OK;
    end else begin
      state   <= state_next;
      ans_g   <= ans_g_next;
      ans_s   <= ans_s_next;
      in_al   <= in_al_next;
      app_sel <= app_sel_next;
      fin_st  <= fin_st_next;
      if (cmd.start) begin
        pend <= 1'b1;
      end else if (st.done) begin
        pend <= 1'b0;
      end
    end
  end

endmodule

@@ sv/two_level_submit_admission.sv @@
// Top level of the two-level submit admission throttle.
// Depends on tlsa_pkg, tlsa_dp and tlsa_ctrl.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  in       | in_valid / in_stall   | in_data  (action, job_id)
//  out      | out_valid / out_stall | out_data (kind, job_out, granted,
//           |                       |           status, last)
//  cfg      | cfg_we                | cfg_index, cfg_data
//
// One transaction is worked at a time. Each list search walks one entry per
// cycle, as does each removal shift. Results leave through a single output
// register; a stall there holds the sequencer. Reset is synchronous and
// empties all lists (counts zero) and restores both limits.
module two_level_submit_admission
  import tlsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  // sequencer: one state per list operation or result
  tlsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // lists, counts, limits and the result register
  tlsa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
